### rtl/core/scba_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the size class block allocator.
package scba_pkg;

    localparam int MAX_CLASSES = 6;
    localparam int CLS_SIZE_W  = 17;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_OOM     = 2'd2,
        ST_BAD_HDR = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_HEAP_BASE  = 3'd0,
        REG_HEAP_LIMIT = 3'd1,
        REG_CLASS_0    = 3'd2,
        REG_CLASS_1    = 3'd3,
        REG_CLASS_2    = 3'd4,
        REG_CLASS_3    = 3'd5,
        REG_CLASS_4    = 3'd6,
        REG_CLASS_5    = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
    } dp_status_t;

endpackage

### rtl/core/size_class_block_allocator.sv
`timescale 1ns / 1ps
// Top level of the size class block allocator.
//
// Requests enter on start/opcode/request_bytes/block_address and are taken
// at a clock edge where start is high and busy is low. opcode selects
// allocate, free or size query. Each request produces exactly one result on
// result_address/block_bytes/status, marked by a one-cycle done strobe.
// The receiver cannot stall; the result is simply present for that cycle.
// A request steps through capture, lookup (with header/link RAM read) and
// commit (with RAM write-back); done rises the cycle after commit, and a new
// request can be taken in that same cycle, but not before.
// Configuration writes (cfg_we/cfg_index/cfg_data) land at once; issue them
// only while the block is idle.
// After reset the header RAM is swept clear, one slot a cycle, through all
// HEAP_BYTES/16 slots (4096 at the defaults); busy stays high meanwhile.
module size_class_block_allocator #(
    parameter int HEAP_BYTES   = 65536,
    parameter int NUM_CLASSES  = 6,
    parameter int HEADER_BYTES = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          opcode,
    input  logic [31:0]                         request_bytes,
    input  logic [31:0]                         block_address,
    output logic                                done,
    output logic [31:0]                         result_address,
    output logic [scba_pkg::CLS_SIZE_W-1:0]     block_bytes,
    output logic [1:0]                          status,
    input  logic                                cfg_we,
    input  logic [scba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data
);
    import scba_pkg::*;

    cmd_t       cmd;
    dp_status_t stat;

    scba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    scba_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .NUM_CLASSES  (NUM_CLASSES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .opcode         (opcode),
        .request_bytes  (request_bytes),
        .block_address  (block_address),
        .done           (done),
        .result_address (result_address),
        .block_bytes    (block_bytes),
        .status         (status)
    );
endmodule

### rtl/core/scba_ram.sv
`timescale 1ns / 1ps
// Generic single write port RAM with registered read.
module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/scba_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the allocator: header clear sweep, lookup and commit steps.
module scba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  scba_pkg::dp_status_t stat,
    output logic                busy,
    output scba_pkg::cmd_t      cmd
);
    import scba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end
endmodule

### rtl/core/scba_datapath.sv
`timescale 1ns / 1ps
// Allocator datapath: config registers, free list heads, header and link RAMs.
module scba_datapath #(
    parameter int HEAP_BYTES   = 65536,
    parameter int NUM_CLASSES  = 6,
    parameter int HEADER_BYTES = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  scba_pkg::cmd_t                      cmd,
    output scba_pkg::dp_status_t                stat,
    input  logic                                cfg_we,
    input  logic [scba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic [1:0]                          opcode,
    input  logic [31:0]                         request_bytes,
    input  logic [31:0]                         block_address,
    output logic                                done,
    output logic [31:0]                         result_address,
    output logic [scba_pkg::CLS_SIZE_W-1:0]     block_bytes,
    output logic [1:0]                          status
);
    import scba_pkg::*;

    localparam int SLOT_COUNT = HEAP_BYTES / 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int HEAD_W     = SLOT_W + 1;
    localparam int SIZE_W     = $clog2(HEAP_BYTES + 1);
    localparam int HDR_W      = SIZE_W + 1;
    localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [HEAD_W-1:0] HEAD_EMPTY = HEAD_W'(SLOT_COUNT);

    // configuration
    logic [31:0]           heap_base_reg;
    logic [31:0]           heap_limit_reg;
    logic [CLS_SIZE_W-1:0] class_reg [MAX_CLASSES];

    // request capture
    op_t         op_reg;
    logic [31:0] req_reg;
    logic [31:0] addr_reg;

    // lookup results
    logic              null_reg;
    logic              pop_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic [31:0]       size_reg;
    logic [33:0]       carve_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              slot_bad_reg;
    logic [HEAD_W-1:0] fh_reg;

    logic [HEAD_W-1:0] free_head_reg [NUM_CLASSES];
    logic [SIZE_W-1:0] bump_reg;
    logic [SLOT_W-1:0] clr_cnt_reg;

    logic                  done_reg;
    logic [31:0]           result_address_reg;
    logic [CLS_SIZE_W-1:0] block_bytes_reg;
    status_t               status_reg;

    logic [NUM_CLASSES-1:0] active;
    logic                   hit;
    logic [CLS_W-1:0]       hit_cls;
    logic                   match;
    logic [CLS_W-1:0]       match_cls;
    logic [HEAD_W-1:0]      match_head;
    logic [31:0]            hdr_addr;
    logic [31:0]            hdr_off;
    logic [HEAD_W-1:0]      head_sel;

    logic              hdr_we;
    logic [SLOT_W-1:0] hdr_waddr;
    logic [HDR_W-1:0]  hdr_wdata;
    logic [SLOT_W-1:0] rd_addr;
    logic [HDR_W-1:0]  hdr_rdata;
    logic              link_we;
    logic [SLOT_W-1:0] link_wdata;
    logic [SLOT_W-1:0] link_rdata;

    logic [33:0] sum_heap;
    logic [33:0] sum_limit;
    logic        oom;
    logic        hdr_valid;
    logic [31:0] hdr_size32;
    logic [HEAD_W-1:0] pop_next;

    always_comb
    begin
        logic run;
        run = 1'b1;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            run       = run && (class_reg[i] != '0);
            active[i] = run;
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_cls = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (active[i] && (req_reg <= 32'(class_reg[i])))
            begin
                hit     = 1'b1;
                hit_cls = CLS_W'(i);
            end
        end
    end

    assign hdr_valid  = hdr_rdata[HDR_W-1];
    assign hdr_size32 = 32'(hdr_rdata[SIZE_W-1:0]);

    always_comb
    begin
        match     = 1'b0;
        match_cls = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (active[i] && (hdr_size32 == 32'(class_reg[i])))
            begin
                match     = 1'b1;
                match_cls = CLS_W'(i);
            end
        end
    end

    assign match_head = free_head_reg[match_cls];

    assign hdr_addr = addr_reg - 32'(HEADER_BYTES);
    assign hdr_off  = hdr_addr - heap_base_reg;
    assign head_sel = free_head_reg[hit_cls];
    assign rd_addr  = (op_reg == OP_ALLOC) ? head_sel[SLOT_W-1:0] : hdr_off[SLOT_W+3:4];

    assign sum_heap  = 34'(bump_reg) + carve_reg;
    assign sum_limit = 34'(heap_base_reg) + 34'(bump_reg) + carve_reg;
    assign oom       = (sum_heap > 34'(HEAP_BYTES)) || (sum_limit > 34'(heap_limit_reg));
    assign pop_next  = ((link_rdata == fh_reg[SLOT_W-1:0]) ||
                        ({1'b0, link_rdata} >= HEAD_EMPTY)) ? HEAD_EMPTY : {1'b0, link_rdata};

    always_comb
    begin
        hdr_we     = 1'b0;
        hdr_waddr  = bump_reg[SLOT_W+3:4];
        hdr_wdata  = {1'b1, size_reg[SIZE_W-1:0]};
        link_we    = 1'b0;
        link_wdata = (match_head == HEAD_EMPTY) ? slot_reg : match_head[SLOT_W-1:0];
        if (cmd.clear)
        begin
            hdr_we    = 1'b1;
            hdr_waddr = clr_cnt_reg;
            hdr_wdata = '0;
        end
        else if (cmd.commit && !null_reg)
        begin
            if (op_reg == OP_ALLOC && !pop_reg && !oom)
            begin
                hdr_we = 1'b1;
            end
            if (op_reg == OP_FREE && !slot_bad_reg && hdr_valid && match)
            begin
                link_we = 1'b1;
            end
        end
    end

    assign stat.clear_done = (clr_cnt_reg == SLOT_W'(SLOT_COUNT - 1));

    scba_ram #(.WIDTH(HDR_W), .DEPTH(SLOT_COUNT)) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (hdr_waddr),
        .wdata (hdr_wdata),
        .raddr (rd_addr),
        .rdata (hdr_rdata)
    );

    scba_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (slot_reg),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= '0;
            heap_limit_reg <= 32'd65536;
            class_reg[0]   <= CLS_SIZE_W'(16);
            class_reg[1]   <= CLS_SIZE_W'(32);
            class_reg[2]   <= CLS_SIZE_W'(64);
            class_reg[3]   <= CLS_SIZE_W'(128);
            class_reg[4]   <= CLS_SIZE_W'(256);
            class_reg[5]   <= CLS_SIZE_W'(512);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                REG_HEAP_LIMIT: heap_limit_reg <= cfg_data;
                REG_CLASS_0:    class_reg[0]   <= cfg_data[CLS_SIZE_W-1:0];
                REG_CLASS_1:    class_reg[1]   <= cfg_data[CLS_SIZE_W-1:0];
                REG_CLASS_2:    class_reg[2]   <= cfg_data[CLS_SIZE_W-1:0];
                REG_CLASS_3:    class_reg[3]   <= cfg_data[CLS_SIZE_W-1:0];
                REG_CLASS_4:    class_reg[4]   <= cfg_data[CLS_SIZE_W-1:0];
                REG_CLASS_5:    class_reg[5]   <= cfg_data[CLS_SIZE_W-1:0];
                default:        heap_base_reg  <= heap_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(opcode);
            req_reg  <= request_bytes;
            addr_reg <= block_address;
        end
        if (cmd.lookup)
        begin
            null_reg     <= (op_reg == OP_ALLOC) ? (req_reg == '0) : (addr_reg == '0);
            pop_reg      <= hit && (head_sel != HEAD_EMPTY);
            cls_reg      <= hit_cls;
            fh_reg       <= head_sel;
            size_reg     <= hit ? 32'(class_reg[hit_cls]) : req_reg;
            carve_reg    <= (34'(HEADER_BYTES) + 34'(hit ? 32'(class_reg[hit_cls]) : req_reg)
                             + 34'd15) & ~34'd15;
            slot_reg     <= hdr_off[SLOT_W+3:4];
            slot_bad_reg <= (hdr_off >= 32'(HEAP_BYTES)) || (hdr_off[3:0] != 4'd0) ||
                            ({1'b0, hdr_off[SLOT_W+3:4]} >= HEAD_EMPTY);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bump_reg    <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                free_head_reg[i] <= HEAD_EMPTY;
            end
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.commit && !null_reg)
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (pop_reg)
                    begin
                        free_head_reg[cls_reg] <= pop_next;
                    end
                    else if (!oom)
                    begin
                        bump_reg <= sum_heap[SIZE_W-1:0];
                    end
                end
                else if (link_we)
                begin
                    free_head_reg[match_cls] <= {1'b0, slot_reg};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_address_reg <= '0;
            block_bytes_reg    <= '0;
            status_reg         <= ST_OK;
            if (op_reg == OP_NONE)
            begin
                status_reg <= ST_OK;
            end
            else if (null_reg)
            begin
                status_reg <= ST_NULL;
            end
            else if (op_reg == OP_ALLOC)
            begin
                if (pop_reg)
                begin
                    result_address_reg <= heap_base_reg + 32'({fh_reg[SLOT_W-1:0], 4'd0})
                                          + 32'(HEADER_BYTES);
                    block_bytes_reg    <= hdr_size32[CLS_SIZE_W-1:0];
                end
                else if (oom)
                begin
                    status_reg <= ST_OOM;
                end
                else
                begin
                    result_address_reg <= heap_base_reg + 32'(bump_reg) + 32'(HEADER_BYTES);
                    block_bytes_reg    <= size_reg[CLS_SIZE_W-1:0];
                end
            end
            else if (slot_bad_reg || !hdr_valid)
            begin
                status_reg <= ST_BAD_HDR;
            end
            else if (op_reg == OP_QUERY)
            begin
                block_bytes_reg <= hdr_size32[CLS_SIZE_W-1:0];
            end
        end
    end

    assign done           = done_reg;
    assign result_address = result_address_reg;
    assign block_bytes    = block_bytes_reg;
    assign status         = status_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held two cycles");
    a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(bump_reg) <= 32'(HEAP_BYTES))
        else $error("bump pointer past heap store");
    a_bump_align: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg[3:0] == 4'd0)
        else $error("bump pointer off slot boundary");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg != ST_OK) |-> (result_address_reg == '0) &&
        (block_bytes_reg == '0))
        else $error("failed request carries payload");
endmodule
